[rtl/core/lft_pkg.sv]
// lft_pkg: shared types and constants of the least frequent top-k core
// word layouts of the request and result channels, command codes, register map
// no dependencies
`default_nettype none

package lft_pkg;

   // fixed field widths
   localparam int VALUE_BITS     = 7;
   localparam int OUT_COUNT_BITS = 16;

   // command codes
   localparam logic CMD_ADD    = 1'b0;
   localparam logic CMD_FINISH = 1'b1;

   // register map: register index taken from paddr[2]
   localparam logic       REG_KEEP_COUNT   = 1'b0;
   localparam logic [1:0] KEEP_COUNT_RESET = 2'd3;

   // request word
   typedef struct packed {
      logic                  command;
      logic [VALUE_BITS-1:0] sample_value;
   } req_type;

   // result word
   typedef struct packed {
      logic [VALUE_BITS-1:0]     found_value;
      logic [OUT_COUNT_BITS-1:0] found_count;
      logic                      found_valid;
      logic                      last_result;
   } rsp_type;

endpackage

`default_nettype wire

[rtl/core/least_frequent_top_k_core.sv]
// least_frequent_top_k_core: histogram with least frequent top-k report
// single module; uses lft_pkg for word types, command codes and register map
//
// usage
//   request channel: a word is taken at a rising edge with start high and busy low.
//   an add word counts sample_value into a saturating histogram bin held in one
//   synchronous ram; adds stream at one word per cycle through a read-modify-write
//   pipeline with forwarding of the previous write.
//   a finish word scans all BIN_COUNT bins, one bin read per cycle from the ram
//   port, clearing each bin as it goes, and keeps the least frequent values in a
//   sorted row of KEEP_MAX slots. the results follow the scan and a drain state,
//   one result per cycle, 1 to keep_count (clamped to 1..KEEP_MAX) results,
//   largest count first; an empty histogram gives one invalid result.
//   busy stays high from the finish word until the last result has gone.
//   result channel: each result is shown for one cycle with rsp_valid high; the
//   receiver cannot stall it.
//   config: apb write to keep_count at byte address 0, pready always high.
//   reset: synchronous; keep_count returns to 3 and a clearing pass over all
//   BIN_COUNT bins zeroes the ram with busy high.
`default_nettype none

module least_frequent_top_k_core #(
   parameter int KEEP_MAX   = 3,
   parameter int BIN_COUNT  = 128,
   parameter int COUNT_BITS = 16
) (
   input  wire                     clock,
   input  wire                     reset,
   // request channel
   input  wire                     start,
   output logic                    busy,
   input  wire  lft_pkg::req_type  req_data,
   // result channel
   output logic                    rsp_valid,
   output lft_pkg::rsp_type        rsp_data,
   // config port
   input  wire                     psel,
   input  wire                     penable,
   input  wire                     pwrite,
   input  wire  [2:0]              paddr,
   input  wire  [31:0]             pwdata,
   output logic [31:0]             prdata,
   output logic                    pready
);

   localparam int ADDR_BITS = (BIN_COUNT > 1) ? $clog2(BIN_COUNT) : 1;
   localparam int FILL_BITS = $clog2(KEEP_MAX + 1);
   localparam logic [ADDR_BITS-1:0] LAST_POS = ADDR_BITS'(BIN_COUNT - 1);

   // state codes
   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_SCAN  = 3'd2;
   localparam logic [2:0] ST_DRAIN = 3'd3;
   localparam logic [2:0] ST_EMIT  = 3'd4;

   // control registers
   logic [2:0]           state_ff, state_in;
   logic [ADDR_BITS-1:0] pos_ff, pos_in;
   logic [1:0]           keep_count_ff, keep_count_in;
   logic [FILL_BITS-1:0] filled_ff, filled_in;
   logic                 rd_valid_ff, rd_valid_in;
   logic                 rd_scan_ff, rd_scan_in;
   logic [ADDR_BITS-1:0] rd_addr_ff, rd_addr_in;
   logic                 wr_valid_ff, wr_valid_in;
   logic [ADDR_BITS-1:0] wr_addr_ff, wr_addr_in;
   logic [COUNT_BITS-1:0] wr_data_ff, wr_data_in;

   // kept slots, sorted by descending count then descending value
   logic [lft_pkg::VALUE_BITS-1:0] kv_ff [KEEP_MAX];
   logic [lft_pkg::VALUE_BITS-1:0] kv_in [KEEP_MAX];
   logic [COUNT_BITS-1:0]          kc_ff [KEEP_MAX];
   logic [COUNT_BITS-1:0]          kc_in [KEEP_MAX];
   logic [KEEP_MAX-1:0]            ku_ff, ku_in;

   // histogram ram
   logic [COUNT_BITS-1:0] mem [BIN_COUNT];
   logic [COUNT_BITS-1:0] mem_q_ff;
   logic [ADDR_BITS-1:0]  mem_raddr;
   logic                  mem_we;
   logic [ADDR_BITS-1:0]  mem_waddr;
   logic [COUNT_BITS-1:0] mem_wdata;

   // datapath helpers
   logic [COUNT_BITS-1:0]          bin_cnt;
   logic [lft_pkg::VALUE_BITS-1:0] bin_val;
   logic [KEEP_MAX-1:0]            above;
   logic [KEEP_MAX-1:0]            above_nx;
   logic [lft_pkg::VALUE_BITS-1:0] kv_nx [KEEP_MAX];
   logic [COUNT_BITS-1:0]          kc_nx [KEEP_MAX];
   logic [KEEP_MAX-1:0]            ku_nx;
   logic [FILL_BITS-1:0]           keep_eff;
   logic                           cfg_write;
   logic                           accept;

   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite;
   assign accept    = start && (state_ff == ST_IDLE);
   assign busy      = (state_ff != ST_IDLE);

   // register read-back
   always_comb begin
      prdata = 32'd0;
      if (paddr[2] == lft_pkg::REG_KEEP_COUNT) begin
         prdata = 32'(keep_count_ff);
      end
   end

   // keep_count clamped to 1..KEEP_MAX
   always_comb begin
      if (keep_count_ff == 2'd0) begin
         keep_eff = FILL_BITS'(1);
      end else if (32'(keep_count_ff) > KEEP_MAX) begin
         keep_eff = FILL_BITS'(KEEP_MAX);
      end else begin
         keep_eff = FILL_BITS'(keep_count_ff);
      end
   end

   // bin read data with forwarding of the write made at the previous edge
   always_comb begin
      if (wr_valid_ff && (wr_addr_ff == rd_addr_ff)) begin
         bin_cnt = wr_data_ff;
      end else begin
         bin_cnt = mem_q_ff;
      end
      bin_val = lft_pkg::VALUE_BITS'(rd_addr_ff);
   end

   // slot ranks above the bin under scan, and the slot row shifted by one
   always_comb begin
      for (int i = 0; i < KEEP_MAX; i++) begin
         above[i] = ku_ff[i] && ((kc_ff[i] > bin_cnt) ||
                    ((kc_ff[i] == bin_cnt) && (kv_ff[i] > bin_val)));
      end
      for (int i = 0; i < KEEP_MAX; i++) begin
         kv_nx[i]    = kv_ff[i];
         kc_nx[i]    = kc_ff[i];
         ku_nx[i]    = 1'b0;
         above_nx[i] = 1'b0;
      end
      for (int i = 0; i < KEEP_MAX - 1; i++) begin
         kv_nx[i]    = kv_ff[i+1];
         kc_nx[i]    = kc_ff[i+1];
         ku_nx[i]    = ku_ff[i+1];
         above_nx[i] = above[i+1];
      end
   end

   // sequencer, bin update and slot update
   always_comb begin
      state_in      = state_ff;
      pos_in        = pos_ff;
      keep_count_in = keep_count_ff;
      filled_in     = filled_ff;
      rd_valid_in   = 1'b0;
      rd_scan_in    = rd_scan_ff;
      rd_addr_in    = rd_addr_ff;
      wr_valid_in   = 1'b0;
      wr_addr_in    = wr_addr_ff;
      wr_data_in    = wr_data_ff;
      kv_in         = kv_ff;
      kc_in         = kc_ff;
      ku_in         = ku_ff;
      mem_raddr     = rd_addr_ff;
      mem_we        = 1'b0;
      mem_waddr     = rd_addr_ff;
      mem_wdata     = '0;
      rsp_valid     = 1'b0;
      rsp_data      = '0;

      if (cfg_write && (paddr[2] == lft_pkg::REG_KEEP_COUNT)) begin
         keep_count_in = pwdata[1:0];
      end

      // second stage: write back a counted bin or take a scanned bin
      if (rd_valid_ff) begin
         mem_we      = 1'b1;
         mem_waddr   = rd_addr_ff;
         wr_valid_in = 1'b1;
         wr_addr_in  = rd_addr_ff;
         if (!rd_scan_ff) begin
            if (bin_cnt == {COUNT_BITS{1'b1}}) begin
               mem_wdata = bin_cnt;
            end else begin
               mem_wdata = bin_cnt + COUNT_BITS'(1);
            end
         end else begin
            mem_wdata = '0;
            if (bin_cnt != '0) begin
               if (filled_ff < keep_eff) begin
                  // insert into sorted row
                  if (!above[0]) begin
                     kv_in[0] = bin_val;
                     kc_in[0] = bin_cnt;
                  end
                  for (int i = 1; i < KEEP_MAX; i++) begin
                     if (!above[i]) begin
                        if (above[i-1]) begin
                           kv_in[i] = bin_val;
                           kc_in[i] = bin_cnt;
                        end else begin
                           kv_in[i] = kv_ff[i-1];
                           kc_in[i] = kc_ff[i-1];
                        end
                     end
                  end
                  for (int i = 0; i < KEEP_MAX; i++) begin
                     if (i == int'(filled_ff)) begin
                        ku_in[i] = 1'b1;
                     end
                  end
                  filled_in = filled_ff + FILL_BITS'(1);
               end else if (bin_cnt < kc_ff[0]) begin
                  // drop the top slot and insert the new bin
                  for (int i = 0; i < KEEP_MAX; i++) begin
                     if (above_nx[i]) begin
                        kv_in[i] = kv_nx[i];
                        kc_in[i] = kc_nx[i];
                     end else if ((i == 0) || above[i]) begin
                        kv_in[i] = bin_val;
                        kc_in[i] = bin_cnt;
                     end
                  end
               end
            end
         end
         wr_data_in = mem_wdata;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = pos_ff;
            mem_wdata = '0;
            pos_in    = pos_ff + ADDR_BITS'(1);
            if (pos_ff == LAST_POS) begin
               pos_in   = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               if (req_data.command == lft_pkg::CMD_ADD) begin
                  if (32'(req_data.sample_value) < BIN_COUNT) begin
                     mem_raddr   = ADDR_BITS'(req_data.sample_value);
                     rd_addr_in  = ADDR_BITS'(req_data.sample_value);
                     rd_scan_in  = 1'b0;
                     rd_valid_in = 1'b1;
                  end
               end else begin
                  pos_in    = '0;
                  filled_in = '0;
                  ku_in     = '0;
                  state_in  = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            mem_raddr   = pos_ff;
            rd_addr_in  = pos_ff;
            rd_scan_in  = 1'b1;
            rd_valid_in = 1'b1;
            pos_in      = pos_ff + ADDR_BITS'(1);
            if (pos_ff == LAST_POS) begin
               pos_in   = '0;
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            rsp_valid = 1'b1;
            if (filled_ff == '0) begin
               rsp_data.last_result = 1'b1;
               state_in             = ST_IDLE;
            end else begin
               rsp_data.found_value = kv_ff[0];
               rsp_data.found_count = lft_pkg::OUT_COUNT_BITS'(kc_ff[0]);
               rsp_data.found_valid = 1'b1;
               rsp_data.last_result = (filled_ff == FILL_BITS'(1));
               kv_in     = kv_nx;
               kc_in     = kc_nx;
               ku_in     = ku_nx;
               filled_in = filled_ff - FILL_BITS'(1);
               if (filled_ff == FILL_BITS'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_CLEAR;
            pos_in   = '0;
         end
      endcase
   end

   // histogram ram, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      mem_q_ff <= mem[mem_raddr];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         pos_ff        <= '0;
         keep_count_ff <= lft_pkg::KEEP_COUNT_RESET;
         filled_ff     <= '0;
         rd_valid_ff   <= 1'b0;
         wr_valid_ff   <= 1'b0;
         ku_ff         <= '0;
      end else begin
         state_ff      <= state_in;
         pos_ff        <= pos_in;
         keep_count_ff <= keep_count_in;
         filled_ff     <= filled_in;
         rd_valid_ff   <= rd_valid_in;
         wr_valid_ff   <= wr_valid_in;
         ku_ff         <= ku_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rd_scan_ff <= rd_scan_in;
      rd_addr_ff <= rd_addr_in;
      wr_addr_ff <= wr_addr_in;
      wr_data_ff <= wr_data_in;
      kv_ff      <= kv_in;
      kc_ff      <= kc_in;
   end

endmodule

`default_nettype wire
